>>> design/apci_pkg.sv
// Shared constants and types of the APCI frame checker.
// Holds the status and frame kind codes and the field widths.
// Depends on nothing.
`default_nettype none

package apci_pkg;

   localparam logic [7:0] START_BYTE   = 8'h68;
   localparam logic [7:0] S_CTRL_BYTE  = 8'h01;
   localparam int         SEQ_W        = 15;
   localparam int         LEN_W        = 16;
   localparam int         UBITS_W      = 6;
   localparam int         CSR_ADDR_W   = 3;
   localparam int         CSR_DATA_W   = 32;

   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_BAD_START   = 4'd1,
      ST_SHORT       = 4'd2,
      ST_S_CTRL      = 4'd3,
      ST_S_ZERO      = 4'd4,
      ST_ODD_RECV    = 4'd5,
      ST_U_NONE      = 4'd6,
      ST_U_MANY      = 4'd7,
      ST_U_NONZERO   = 4'd8,
      ST_EXTRA_BYTES = 4'd9
   } status_type;

   typedef enum logic [1:0] {
      KIND_I = 2'd0,
      KIND_S = 2'd1,
      KIND_U = 2'd2
   } kind_type;

   // Register index of the length field size
   localparam logic [0:0] REG_LENGTH_FIELD_BYTES = 1'b0;

   function automatic kind_type kind_of(input logic [7:0] ctrl);
      kind_type k;
      if (!ctrl[0]) begin
         k = KIND_I;
      end else if (ctrl[1]) begin
         k = KIND_U;
      end else begin
         k = KIND_S;
      end
      return k;
   endfunction

endpackage

`default_nettype wire

>>> design/telecontrol_apci_frame_checker.sv
// Top level of the APCI frame checker: byte stream in, one status item per frame out.
// Uses apci_pkg for codes, widths and the frame kind decode.
//
//  channel | dir | handshake                 | payload
//  req     | in  | tvalid/tready             | tdata[7:0] data_byte, tlast frame_end
//  rsp     | out | tvalid/tready             | tdata status..expected_receive, tuser frame_kind
//  csr     | in  | psel/penable/pwrite/pready| length_field_bytes at address 0
//
// One byte is taken per cycle; the frame state registers absorb each byte in that cycle.
// The item for a frame is loaded into the output register on the byte marked last and
// is shown in the next cycle. A byte is held off while an item waits in the output
// register and the result side is stalled; with the result side ready, bytes flow
// back to back. Synchronous reset clears the frame state, next receive number,
// output valid and sets the length field size to one byte.
`default_nettype none

module telecontrol_apci_frame_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // data_byte [7:0]
   input  wire logic [7:0]                        req_tdata,
   input  wire logic                              req_tlast,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // status [3:0], send_number [18:4], ack_number [33:19], unnumbered_bits [39:34],
   // length_value [55:40], expected_receive [70:56], zero [71]
   output      logic [71:0]                       rsp_tdata,
   // frame_kind [1:0]
   output      logic [1:0]                        rsp_tuser,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [apci_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [apci_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output      logic [apci_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output      logic                              csr_pready
);

   localparam int SEQ_W   = apci_pkg::SEQ_W;
   localparam int LEN_W   = apci_pkg::LEN_W;
   localparam int UBITS_W = apci_pkg::UBITS_W;

   // configuration
   logic [1:0] lfb_ff, lfb_in;
   logic       csr_write;

   // frame state
   logic [7:0]       pos_ff, pos_in;
   logic [3:0]       fault_ff, fault_in;
   logic [7:0]       cf_ff, cf_in;
   logic [15:0]      na_ff, na_in;
   logic [15:0]      nb_ff, nb_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [SEQ_W-1:0] nrecv_ff, nrecv_in;

   // output register
   logic                  out_valid_ff, out_valid_in;
   apci_pkg::status_type  out_status_ff, out_status_in;
   apci_pkg::kind_type    out_kind_ff, out_kind_in;
   logic [SEQ_W-1:0]      out_snd_ff, out_snd_in;
   logic [SEQ_W-1:0]      out_ack_ff, out_ack_in;
   logic [UBITS_W-1:0]    out_ub_ff, out_ub_in;
   logic [LEN_W-1:0]      out_len_ff, out_len_in;
   logic [SEQ_W-1:0]      out_exp_ff, out_exp_in;

   // per byte decode
   logic                 accept;
   logic [7:0]           lb;
   logic                 in_len, in_ctrl;
   logic [1:0]           ctrl_k;
   logic [7:0]           cf_eff;
   apci_pkg::kind_type   kind_now;
   logic [UBITS_W-1:0]   ubits_now;
   logic [3:0]           byte_fault;
   logic [3:0]           fault_nx;
   logic [7:0]           cf_nx;
   logic [15:0]          na_nx, nb_nx;
   logic [LEN_W-1:0]     len_nx;
   logic                 is_short, is_long;
   logic [SEQ_W-1:0]     snd_nx;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !out_valid_ff || rsp_tready;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      lfb_in = lfb_ff;
      if (csr_write && (csr_paddr[2] == apci_pkg::REG_LENGTH_FIELD_BYTES)) begin
         lfb_in = csr_pwdata[1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == apci_pkg::REG_LENGTH_FIELD_BYTES) begin
         csr_prdata = {{(apci_pkg::CSR_DATA_W-2){1'b0}}, lfb_ff};
      end
   end

   // ---------------- byte decode ----------------
   always_comb begin
      lb        = lfb_ff[1] ? 8'd2 : 8'd1;
      in_len    = (pos_ff != 8'd0) && (pos_ff <= lb);
      in_ctrl   = (pos_ff > lb) && (pos_ff <= lb + 8'd4);
      ctrl_k    = 2'(pos_ff - lb - 8'd1);
      cf_eff    = (in_ctrl && (ctrl_k == 2'd0)) ? req_tdata : cf_ff;
      kind_now  = apci_pkg::kind_of(cf_eff);
      ubits_now = req_tdata[7:2];

      // fault raised by this byte alone
      byte_fault = apci_pkg::ST_OK;
      if (pos_ff == 8'd0) begin
         if (req_tdata != apci_pkg::START_BYTE) begin
            byte_fault = apci_pkg::ST_BAD_START;
         end
      end else if (in_ctrl) begin
         case (kind_now)
            apci_pkg::KIND_U: begin
               if (ctrl_k == 2'd0) begin
                  if (ubits_now == '0) begin
                     byte_fault = apci_pkg::ST_U_NONE;
                  end else if ((ubits_now & (ubits_now - 1'b1)) != '0) begin
                     byte_fault = apci_pkg::ST_U_MANY;
                  end
               end else if (req_tdata != 8'd0) begin
                  byte_fault = apci_pkg::ST_U_NONZERO;
               end
            end
            apci_pkg::KIND_S: begin
               if (ctrl_k == 2'd0) begin
                  if (req_tdata != apci_pkg::S_CTRL_BYTE) begin
                     byte_fault = apci_pkg::ST_S_CTRL;
                  end
               end else if (ctrl_k == 2'd1) begin
                  if (req_tdata != 8'd0) begin
                     byte_fault = apci_pkg::ST_S_ZERO;
                  end
               end else if (ctrl_k == 2'd2 && req_tdata[0]) begin
                  byte_fault = apci_pkg::ST_ODD_RECV;
               end
            end
            default: begin
               if (ctrl_k == 2'd2 && req_tdata[0]) begin
                  byte_fault = apci_pkg::ST_ODD_RECV;
               end
            end
         endcase
      end

      // keep the first fault in byte order
      fault_nx = (fault_ff != apci_pkg::ST_OK) ? fault_ff : byte_fault;

      cf_nx = cf_ff;
      na_nx = na_ff;
      nb_nx = nb_ff;
      if (in_ctrl) begin
         case (ctrl_k)
            2'd0: begin
               cf_nx = req_tdata;
               na_nx = {na_ff[15:8], req_tdata};
            end
            2'd1: na_nx = {req_tdata, na_ff[7:0]};
            2'd2: nb_nx = {nb_ff[15:8], req_tdata};
            default: nb_nx = {req_tdata, nb_ff[7:0]};
         endcase
      end

      len_nx = len_ff;
      if (in_len) begin
         if (pos_ff == 8'd1) begin
            len_nx = len_ff | {8'd0, req_tdata};
         end else begin
            len_nx = len_ff | {req_tdata, 8'd0};
         end
      end

      // frame length against start + length field + four control bytes
      is_short = pos_ff < lb + 8'd4;
      is_long  = pos_ff > lb + 8'd4;
      snd_nx   = na_nx[SEQ_W:1] + 1'b1;
   end

   // ---------------- state and result ----------------
   always_comb begin
      pos_in   = pos_ff;
      fault_in = fault_ff;
      cf_in    = cf_ff;
      na_in    = na_ff;
      nb_in    = nb_ff;
      len_in   = len_ff;
      nrecv_in = nrecv_ff;

      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_kind_in   = out_kind_ff;
      out_snd_in    = out_snd_ff;
      out_ack_in    = out_ack_ff;
      out_ub_in     = out_ub_ff;
      out_len_in    = out_len_ff;
      out_exp_in    = out_exp_ff;

      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      if (accept) begin
         if (req_tlast) begin
            // close the frame and clear per-frame state
            pos_in   = '0;
            fault_in = '0;
            cf_in    = '0;
            na_in    = '0;
            nb_in    = '0;
            len_in   = '0;

            out_valid_in = 1'b1;
            out_kind_in  = apci_pkg::KIND_I;
            out_snd_in   = '0;
            out_ack_in   = '0;
            out_ub_in    = '0;
            out_len_in   = len_nx;
            if (fault_nx == apci_pkg::ST_BAD_START) begin
               out_status_in = apci_pkg::ST_BAD_START;
               out_len_in    = '0;
            end else if (is_short) begin
               out_status_in = apci_pkg::ST_SHORT;
            end else begin
               if (fault_nx != apci_pkg::ST_OK) begin
                  out_status_in = apci_pkg::status_type'(fault_nx);
               end else if (is_long) begin
                  out_status_in = apci_pkg::ST_EXTRA_BYTES;
               end else begin
                  out_status_in = apci_pkg::ST_OK;
               end
               out_kind_in = apci_pkg::kind_of(cf_nx);
               case (apci_pkg::kind_of(cf_nx))
                  apci_pkg::KIND_I: begin
                     out_snd_in = na_nx[SEQ_W:1];
                     out_ack_in = nb_nx[SEQ_W:1];
                     nrecv_in   = snd_nx;
                  end
                  apci_pkg::KIND_S: out_ack_in = nb_nx[SEQ_W:1];
                  default:          out_ub_in  = cf_nx[7:2];
               endcase
            end
            out_exp_in = (!is_short && fault_nx != apci_pkg::ST_BAD_START &&
                          apci_pkg::kind_of(cf_nx) == apci_pkg::KIND_I) ? snd_nx : nrecv_ff;
         end else begin
            // advance within the frame, position saturates
            pos_in   = (pos_ff == 8'hFF) ? pos_ff : pos_ff + 8'd1;
            fault_in = fault_nx;
            cf_in    = cf_nx;
            na_in    = na_nx;
            nb_in    = nb_nx;
            len_in   = len_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfb_ff       <= 2'd1;
         pos_ff       <= '0;
         fault_ff     <= '0;
         cf_ff        <= '0;
         na_ff        <= '0;
         nb_ff        <= '0;
         len_ff       <= '0;
         nrecv_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         lfb_ff       <= lfb_in;
         pos_ff       <= pos_in;
         fault_ff     <= fault_in;
         cf_ff        <= cf_in;
         na_ff        <= na_in;
         nb_ff        <= nb_in;
         len_ff       <= len_in;
         nrecv_ff     <= nrecv_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_kind_ff   <= out_kind_in;
      out_snd_ff    <= out_snd_in;
      out_ack_ff    <= out_ack_in;
      out_ub_ff     <= out_ub_in;
      out_len_ff    <= out_len_in;
      out_exp_ff    <= out_exp_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {1'b0, out_exp_ff, out_len_ff, out_ub_ff, out_ack_ff, out_snd_ff,
                        out_status_ff};

endmodule

`default_nettype wire
